// File: rtl/core/sad_pkg.sv
package sad_pkg;

    localparam int MAX_CLASSES_DEF = 16;
    localparam int NUM_W           = 5;
    localparam logic [NUM_W-1:0] NUM_CLASSES_RST = 5'd10;
    localparam int LOGIT_W         = 16;
    localparam int PROB_W          = 17;
    localparam int SLOT_W          = 4;
    localparam int NUM_W_EXT       = 7;
    localparam int QBITS           = 17;
    localparam int NUMER_W         = 34;
    localparam int FLUSH_LIMIT     = 2839;
    localparam logic [16:0] LOG2E_Q16 = 17'd94548;
    localparam logic [15:0] LN2_Q16   = 16'd45426;

    typedef logic [3:0] t_op;
    localparam t_op OP_NONE  = 4'd0;
    localparam t_op OP_LOAD  = 4'd1;
    localparam t_op OP_ERR   = 4'd2;
    localparam t_op OP_ET    = 4'd3;
    localparam t_op OP_EX    = 4'd4;
    localparam t_op OP_EXX   = 4'd5;
    localparam t_op OP_EPR   = 4'd6;
    localparam t_op OP_EWR   = 4'd7;
    localparam t_op OP_DINIT = 4'd8;
    localparam t_op OP_DITER = 4'd9;
    localparam t_op OP_DWR   = 4'd10;
    localparam t_op OP_OLD   = 4'd11;

    typedef struct packed {
        t_op  op;
        logic first;
        logic last;
    } t_cmd;

    typedef struct packed {
        logic out_busy;
    } t_stat;

    // 2^(-i/16) in Q16.
    function automatic logic [16:0] exp_tab(input logic [3:0] i);
        logic [16:0] v;
        unique case (i)
            4'd0:    v = 17'd65536;
            4'd1:    v = 17'd62757;
            4'd2:    v = 17'd60097;
            4'd3:    v = 17'd57549;
            4'd4:    v = 17'd55108;
            4'd5:    v = 17'd52773;
            4'd6:    v = 17'd50535;
            4'd7:    v = 17'd48392;
            4'd8:    v = 17'd46341;
            4'd9:    v = 17'd44378;
            4'd10:   v = 17'd42495;
            4'd11:   v = 17'd40693;
            4'd12:   v = 17'd38968;
            4'd13:   v = 17'd37316;
            4'd14:   v = 17'd35734;
            default: v = 17'd34219;
        endcase
        return v;
    endfunction

endpackage

// File: rtl/core/sad_ram.sv
module sad_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/sad_ctrl.sv
module sad_ctrl #(
    parameter int MAX_CLASSES = sad_pkg::MAX_CLASSES_DEF,
    localparam int IW = $clog2(MAX_CLASSES)
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [sad_pkg::NUM_W-1:0] i_cfg_wdata,
    input  logic                     i_in_valid,
    input  logic                     i_in_last,
    output logic                     o_in_ready,
    input  sad_pkg::t_stat           i_stat,
    output sad_pkg::t_cmd            o_cmd,
    output logic [IW-1:0]            o_addr,
    output logic [IW-1:0]            o_waddr
);

    localparam int SW = 4;
    localparam int XW = sad_pkg::NUM_W_EXT;
    localparam logic [SW-1:0] S_IDLE  = 4'd0;
    localparam logic [SW-1:0] S_ERR   = 4'd1;
    localparam logic [SW-1:0] S_ERD   = 4'd2;
    localparam logic [SW-1:0] S_ET    = 4'd3;
    localparam logic [SW-1:0] S_EX    = 4'd4;
    localparam logic [SW-1:0] S_EXX   = 4'd5;
    localparam logic [SW-1:0] S_EPR   = 4'd6;
    localparam logic [SW-1:0] S_EWR   = 4'd7;
    localparam logic [SW-1:0] S_DRD   = 4'd8;
    localparam logic [SW-1:0] S_DINIT = 4'd9;
    localparam logic [SW-1:0] S_DITER = 4'd10;
    localparam logic [SW-1:0] S_DWR   = 4'd11;
    localparam logic [SW-1:0] S_ORD   = 4'd12;
    localparam logic [SW-1:0] S_OLD   = 4'd13;

    logic [SW-1:0]             r_state, n_state;
    logic [sad_pkg::NUM_W-1:0] r_num;
    logic [sad_pkg::NUM_W-1:0] r_cnt, n_cnt;
    logic [IW-1:0]             r_k, n_k;
    logic [4:0]                r_it, n_it;
    logic [sad_pkg::NUM_W-1:0] cnt_inc;
    logic                      k_last, k_first, accept, store, bad;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign cnt_inc    = (r_cnt == 5'd31) ? r_cnt : r_cnt + 5'd1;
    assign store      = (r_cnt < r_num) && (XW'(r_cnt) < XW'(MAX_CLASSES));
    assign bad        = (r_num == '0) || (XW'(r_num) > XW'(MAX_CLASSES)) || (cnt_inc != r_num);
    assign k_last     = (XW'(r_k) + XW'(1)) == XW'(r_num);
    assign k_first    = (r_k == '0);
    assign o_addr     = r_k;
    assign o_waddr    = IW'(r_cnt);

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_k         = r_k;
        n_it        = r_it;
        o_cmd.op    = sad_pkg::OP_NONE;
        o_cmd.first = k_first;
        o_cmd.last  = k_last;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (store) begin
                        o_cmd.op = sad_pkg::OP_LOAD;
                    end
                    n_cnt = cnt_inc;
                    if (i_in_last) begin
                        n_cnt   = '0;
                        n_k     = '0;
                        n_state = bad ? S_ERR : S_ERD;
                    end
                end
            end
            S_ERR: begin
                if (!i_stat.out_busy) begin
                    o_cmd.op = sad_pkg::OP_ERR;
                    n_state  = S_IDLE;
                end
            end
            S_ERD: n_state = S_ET;
            S_ET: begin
                o_cmd.op = sad_pkg::OP_ET;
                n_state  = S_EX;
            end
            S_EX: begin
                o_cmd.op = sad_pkg::OP_EX;
                n_state  = S_EXX;
            end
            S_EXX: begin
                o_cmd.op = sad_pkg::OP_EXX;
                n_state  = S_EPR;
            end
            S_EPR: begin
                o_cmd.op = sad_pkg::OP_EPR;
                n_state  = S_EWR;
            end
            S_EWR: begin
                o_cmd.op = sad_pkg::OP_EWR;
                if (k_last) begin
                    n_k     = '0;
                    n_state = S_DRD;
                end else begin
                    n_k     = r_k + IW'(1);
                    n_state = S_ERD;
                end
            end
            S_DRD: n_state = S_DINIT;
            S_DINIT: begin
                o_cmd.op = sad_pkg::OP_DINIT;
                n_it     = '0;
                n_state  = S_DITER;
            end
            S_DITER: begin
                o_cmd.op = sad_pkg::OP_DITER;
                n_it     = r_it + 5'd1;
                if (r_it == 5'(sad_pkg::QBITS - 1)) begin
                    n_state = S_DWR;
                end
            end
            S_DWR: begin
                o_cmd.op = sad_pkg::OP_DWR;
                if (k_last) begin
                    n_k     = '0;
                    n_state = S_ORD;
                end else begin
                    n_k     = r_k + IW'(1);
                    n_state = S_DRD;
                end
            end
            S_ORD: n_state = S_OLD;
            S_OLD: begin
                if (!i_stat.out_busy) begin
                    o_cmd.op = sad_pkg::OP_OLD;
                    if (k_last) begin
                        n_k     = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_k     = r_k + IW'(1);
                        n_state = S_ORD;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_num   <= sad_pkg::NUM_CLASSES_RST;
            r_cnt   <= '0;
            r_k     <= '0;
            r_it    <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_k     <= n_k;
            r_it    <= n_it;
            if (i_cfg_we) begin
                r_num <= i_cfg_wdata;
            end
        end
    end

endmodule

// File: rtl/core/sad_dp.sv
module sad_dp #(
    parameter int MAX_CLASSES = sad_pkg::MAX_CLASSES_DEF,
    localparam int IW = $clog2(MAX_CLASSES)
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  sad_pkg::t_cmd                 i_cmd,
    input  logic [IW-1:0]                 i_addr,
    input  logic [IW-1:0]                 i_waddr,
    input  logic signed [sad_pkg::LOGIT_W-1:0] i_logit,
    output sad_pkg::t_stat                o_stat,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [sad_pkg::SLOT_W-1:0]    o_slot,
    output logic [sad_pkg::PROB_W-1:0]    o_prob,
    output logic [sad_pkg::SLOT_W-1:0]    o_best,
    output logic [sad_pkg::PROB_W-1:0]    o_conf,
    output logic                          o_err,
    output logic                          o_last
);

    localparam int PW = sad_pkg::PROB_W;
    localparam int SUMW = PW + IW;
    localparam int NW = sad_pkg::NUMER_W;

    logic signed [15:0] r_max;
    logic [SUMW-1:0]    r_sum;
    logic [15:0]        logit_rd;
    logic [PW-1:0]      exp_rd, exp_wd;
    logic               exp_we;

    // Exponential pipeline registers.
    logic               r_flush;
    logic [28:0]        r_t;
    logic [19:0]        r_x;
    logic [4:0]         r_n;
    logic [3:0]         r_i;
    logic [24:0]        r_p;
    logic [41:0]        r_prod;

    // Divider registers.
    logic [SUMW-1:0]    r_rem;
    logic [PW-1:0]      r_nlo;
    logic [PW-1:0]      r_q;

    logic [IW-1:0]      r_best;
    logic [PW-1:0]      r_conf;

    logic               r_ovalid, r_oerr, r_olast;
    logic [sad_pkg::SLOT_W-1:0] r_oslot, r_obest;
    logic [PW-1:0]      r_oprob, r_oconf;

    logic [16:0]        negd;
    logic [35:0]        xprod;
    logic [39:0]        xsq;
    logic [42:0]        rnd_sum;
    logic [PW-1:0]      exp_val;
    logic [NW-1:0]      numer;
    logic [SUMW:0]      rem_sh;
    logic               rem_ge;

    sad_ram #(.WIDTH(16), .DEPTH(MAX_CLASSES)) u_logit_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.op == sad_pkg::OP_LOAD),
        .i_waddr (i_waddr),
        .i_wdata (i_logit),
        .i_raddr (i_addr),
        .o_rdata (logit_rd)
    );

    assign exp_we = (i_cmd.op == sad_pkg::OP_EWR) || (i_cmd.op == sad_pkg::OP_DWR);
    assign exp_wd = (i_cmd.op == sad_pkg::OP_EWR) ? exp_val : r_q;

    sad_ram #(.WIDTH(PW), .DEPTH(MAX_CLASSES)) u_exp_ram (
        .i_clk   (i_clk),
        .i_we    (exp_we),
        .i_waddr (i_addr),
        .i_wdata (exp_wd),
        .i_raddr (i_addr),
        .o_rdata (exp_rd)
    );

    assign negd    = 17'(17'(r_max) - 17'(signed'(logit_rd)));
    assign xprod   = 36'(r_t[19:0]) * 36'(sad_pkg::LN2_Q16);
    assign xsq     = 40'(r_x) * 40'(r_x);
    assign rnd_sum = 43'(r_prod) + (43'(1) << (6'd23 + 6'(r_n)));
    assign exp_val = r_flush ? '0 : PW'(rnd_sum >> (6'd24 + 6'(r_n)));
    assign numer   = (NW'(exp_rd) << 16) + NW'(r_sum >> 1);
    assign rem_sh  = {r_rem, r_nlo[PW-1]};
    assign rem_ge  = rem_sh >= (SUMW+1)'(r_sum);

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            sad_pkg::OP_ET: begin
                r_flush <= (signed'(negd) > 17'sd0 ? negd : 17'd0) > 17'(sad_pkg::FLUSH_LIMIT);
                r_t     <= 29'(negd[11:0]) * 29'(sad_pkg::LOG2E_Q16);
            end
            sad_pkg::OP_EX: begin
                r_x <= xprod[35:16];
                r_n <= r_t[28:24];
                r_i <= r_t[23:20];
            end
            sad_pkg::OP_EXX: begin
                r_p <= 25'(25'h100_0000 - 25'(r_x) + 25'(xsq >> 25));
            end
            sad_pkg::OP_EPR: begin
                r_prod <= 42'(sad_pkg::exp_tab(r_i)) * 42'(r_p);
            end
            sad_pkg::OP_DINIT: begin
                r_rem <= SUMW'(numer[NW-1:PW]);
                r_nlo <= numer[PW-1:0];
                r_q   <= '0;
            end
            sad_pkg::OP_DITER: begin
                r_rem <= rem_ge ? SUMW'(rem_sh - (SUMW+1)'(r_sum)) : SUMW'(rem_sh);
                r_nlo <= {r_nlo[PW-2:0], 1'b0};
                r_q   <= {r_q[PW-2:0], rem_ge};
            end
            sad_pkg::OP_DWR: begin
                if (i_cmd.first || r_q > r_conf) begin
                    r_conf <= r_q;
                    r_best <= i_addr;
                end
            end
            default: begin
            end
        endcase
        if (i_cmd.op == sad_pkg::OP_OLD) begin
            r_oslot <= sad_pkg::SLOT_W'(i_addr);
            r_oprob <= exp_rd;
            r_obest <= sad_pkg::SLOT_W'(r_best);
            r_oconf <= r_conf;
        end else if (i_cmd.op == sad_pkg::OP_ERR) begin
            r_oslot <= '0;
            r_oprob <= '0;
            r_obest <= '0;
            r_oconf <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max    <= 16'sh8000;
            r_sum    <= '0;
            r_ovalid <= 1'b0;
            r_oerr   <= 1'b0;
            r_olast  <= 1'b0;
        end else begin
            if (i_cmd.op == sad_pkg::OP_LOAD && i_logit > r_max) begin
                r_max <= i_logit;
            end
            if (i_cmd.op == sad_pkg::OP_EWR) begin
                r_sum <= r_sum + SUMW'(exp_val);
            end
            if (i_cmd.op == sad_pkg::OP_ERR ||
                (i_cmd.op == sad_pkg::OP_OLD && i_cmd.last)) begin
                r_max <= 16'sh8000;
                r_sum <= '0;
            end
            if (i_cmd.op == sad_pkg::OP_OLD) begin
                r_ovalid <= 1'b1;
                r_oerr   <= 1'b0;
                r_olast  <= i_cmd.last;
            end else if (i_cmd.op == sad_pkg::OP_ERR) begin
                r_ovalid <= 1'b1;
                r_oerr   <= 1'b1;
                r_olast  <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_stat.out_busy = r_ovalid && !i_ready;
    assign o_valid = r_ovalid;
    assign o_slot  = r_oslot;
    assign o_prob  = r_oprob;
    assign o_best  = r_obest;
    assign o_conf  = r_oconf;
    assign o_err   = r_oerr;
    assign o_last  = r_olast;

endmodule

// File: rtl/core/softmax_argmax_decoder_top.sv
// Softmax with maximum subtraction and argmax over one vector of logits.
// The input stream carries one signed Q8.8 logit per transaction, with tlast on
// the last logit of a vector. While a vector is being received, one logit is
// taken every cycle. On the tlast transaction the block stops accepting input
// and, if the vector is valid, runs three passes over the stored classes: an
// exponential pass (the RAM read and one step per multiplier stage), a
// division pass (a bit-serial restoring divider, one quotient bit per cycle)
// and an output pass; the division pass is the longest. Each output
// transaction carries one class probability plus the best class and its
// confidence; tlast marks the final result of the vector. A count mismatch
// or a bad num_classes yields a single result with tuser set and tlast high.
// When the receiver stalls, the output register holds its transaction and the
// output pass waits. Reset (synchronous, active low) restores num_classes to
// 10, empties the output register and clears the running maximum; no memory
// clearing pass is needed. The user must write num_classes through i_cfg_we
// only while idle; the block itself does not enforce it.
module softmax_argmax_decoder_top #(
    parameter int MAX_CLASSES = sad_pkg::MAX_CLASSES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [4:0]  i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] logit
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [3:0] class_slot, [20:4] probability, [24:21] best_class,
    // [41:25] confidence, [47:42] zero
    output logic [47:0] m_axis_tdata,
    output logic        m_axis_tuser,   // [0] error
    output logic        m_axis_tlast
);

    localparam int IW = $clog2(MAX_CLASSES);

    sad_pkg::t_cmd  cmd;
    sad_pkg::t_stat stat;
    logic [IW-1:0]  addr, waddr;
    logic [3:0]     slot, best;
    logic [16:0]    prob, conf;

    // The controller sequences receive, exponential, divide and output passes.
    sad_ctrl #(.MAX_CLASSES(MAX_CLASSES)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (s_axis_tvalid),
        .i_in_last   (s_axis_tlast),
        .o_in_ready  (s_axis_tready),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_addr      (addr),
        .o_waddr     (waddr)
    );

    // The datapath holds the stores, arithmetic and the output register.
    sad_dp #(.MAX_CLASSES(MAX_CLASSES)) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_addr  (addr),
        .i_waddr (waddr),
        .i_logit (s_axis_tdata),
        .o_stat  (stat),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_slot  (slot),
        .o_prob  (prob),
        .o_best  (best),
        .o_conf  (conf),
        .o_err   (m_axis_tuser),
        .o_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {6'd0, conf, best, prob, slot};

`ifndef SYNTHESIS
    // An error result is always the only, and so the final, result of a vector.
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
        else $error("error result without tlast");

    // No probability exceeds one.
    a_prob_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[20:4] <= 17'd65536)
        else $error("probability above 1.0");

    // The confidence is the maximum, so no class probability exceeds it.
    a_conf_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[20:4] <= m_axis_tdata[41:25])
        else $error("probability above confidence");

    // Input is never taken while results of a vector are still being produced.
    a_no_in_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast |=> !s_axis_tready)
        else $error("input accepted during processing");
`endif

endmodule

// File: tb/softmax_argmax_decoder_top_test.sv
module softmax_argmax_decoder_top_test;

    // Clock, reset and the block's inputs. Every input starts at a known value.
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [4:0]  i_cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;   // [15:0] logit
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    // [3:0] class_slot, [20:4] probability, [24:21] best_class,
    // [41:25] confidence, [47:42] zero
    logic [47:0] m_axis_tdata;
    logic        m_axis_tuser;        // [0] error
    logic        m_axis_tlast;

    always #6 i_clk = ~i_clk;

    softmax_argmax_decoder_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // One expected class result, in the order the fields travel on the bus.
    typedef struct packed {
        logic [sad_pkg::SLOT_W-1:0] slot;
        logic [sad_pkg::PROB_W-1:0] prob;
        logic [sad_pkg::SLOT_W-1:0] best;
        logic [sad_pkg::PROB_W-1:0] conf;
        logic              err;
        logic              last;
    } t_class_result;

    t_class_result class_results_due[$];

    // The predictor's own copy of the configuration and the vector state.
    logic [4:0]          num_classes_cfg;
    logic signed [15:0]  logit_mem [sad_pkg::MAX_CLASSES_DEF];
    logic [4:0]          logit_count;
    logic signed [15:0]  peak_logit;

    int  error_count;
    int  cycle_count;
    bit  idle_enable;      // random gaps on both sides when set
    bit  sink_hold;        // receiver holds off while set
    int  hold_cycles;      // length of the requested hold-off

    localparam int CYCLE_LIMIT = 600000;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got %0d expected %0d (cycle %0d)", what, got, want,
                 cycle_count);
        error_count++;
    endtask

    // Exponential of a non-positive Q8.8 difference, in Q1.16.
    function automatic logic [16:0] exp_of_diff(input int d);
        logic [63:0] t, r, x, p, prod;
        int n, i;
        if (d > 0) d = 0;
        if (d < -sad_pkg::FLUSH_LIMIT) return 17'd0;
        t = 64'(-d) * 64'd94548;
        n = int'(t >> 24);
        i = int'((t >> 20) & 64'd15);
        r = t & 64'hFFFFF;
        x = (r * 64'd45426) >> 16;
        p = (64'd1 << 24) - x + ((x * x) >> 25);
        prod = 64'(sad_pkg::exp_tab(4'(i))) * p;
        if (n > 30) return 17'd0;
        return 17'((prod + (64'd1 << (23 + n))) >> (24 + n));
    endfunction

    // Takes one accepted logit and queues the class results it completes.
    task automatic predict_logit(input logic signed [15:0] logit, input logic eov);
        logic [16:0] exps [sad_pkg::MAX_CLASSES_DEF];
        logic [16:0] probs [sad_pkg::MAX_CLASSES_DEF];
        logic [31:0] sum;
        logic [16:0] conf;
        int best;
        t_class_result res;
        if (logit_count < num_classes_cfg && logit_count < sad_pkg::MAX_CLASSES_DEF) begin
            logit_mem[logit_count] = logit;
            if (logit > peak_logit) peak_logit = logit;
        end
        if (logit_count < 31) logit_count++;
        if (!eov) return;
        if (num_classes_cfg == 0 || num_classes_cfg > sad_pkg::MAX_CLASSES_DEF ||
            logit_count != num_classes_cfg) begin
            res = '0;
            res.err = 1'b1;
            res.last = 1'b1;
            class_results_due.push_back(res);
        end else begin
            sum = 0;
            for (int k = 0; k < logit_count; k++) begin
                exps[k] = exp_of_diff(int'(logit_mem[k]) - int'(peak_logit));
                sum += exps[k];
            end
            if (sum == 0) sum = 1;
            conf = 0;
            best = 0;
            for (int k = 0; k < logit_count; k++) begin
                probs[k] = 17'(((64'(exps[k]) << 16) + sum / 2) / sum);
                if (k == 0 || probs[k] > conf) begin
                    conf = probs[k];
                    best = k;
                end
            end
            for (int k = 0; k < logit_count; k++) begin
                res.slot = 4'(k);
                res.prob = probs[k];
                res.best = 4'(best);
                res.conf = conf;
                res.err = 1'b0;
                res.last = (k + 1 == logit_count);
                class_results_due.push_back(res);
            end
        end
        logit_count = '0;
        peak_logit = -16'sd32768;
    endtask

    // Sends one logit and waits for its transaction; the valid stays high when
    // the next call follows straight away.
    task automatic send_logit(input logic [15:0] logit, input logic eov);
        if (idle_enable) begin
            while ($urandom_range(99) < 16) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= logit;
        s_axis_tlast  <= eov;
        do @(posedge i_clk); while (!s_axis_tready);
        predict_logit(logit, eov);
    endtask

    task automatic pause_send();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Waits until every expected result has come, then lets the block settle
    // so that a vector with nothing left to emit is surely finished.
    task automatic drain_results();
        pause_send();
        while (class_results_due.size() != 0) @(posedge i_clk);
        repeat (600) @(posedge i_clk);
    endtask

    task automatic set_num_classes(input logic [4:0] value);
        drain_results();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        num_classes_cfg = value;
        logit_count = '0;
        peak_logit = -16'sd32768;
    endtask

    task automatic send_vector(input int len, input int spread);
        for (int k = 0; k < len; k++) begin
            send_logit(16'($urandom_range(2 * spread) - spread), k == len - 1);
        end
    endtask

    // Receiver: idles at random and honors the hold-off request.
    always @(posedge i_clk) begin
        if (!i_rst_n || sink_hold) begin
            m_axis_tready <= 1'b0;
        end else if (idle_enable) begin
            m_axis_tready <= ($urandom_range(99) >= 16);
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            sink_hold   <= 1'b1;
            hold_cycles <= hold_cycles - 1;
        end else begin
            sink_hold <= 1'b0;
        end
    end

    // Checker: each output transaction is compared with the oldest expectation.
    always @(posedge i_clk) begin
        t_class_result want;
        cycle_count <= cycle_count + 1;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (class_results_due.size() == 0) begin
                report_mismatch("unexpected result slot", int'(m_axis_tdata[3:0]), -1);
            end else begin
                want = class_results_due.pop_front();
                if (m_axis_tdata[3:0] !== want.slot)
                    report_mismatch("class_slot", m_axis_tdata[3:0], want.slot);
                if (m_axis_tdata[20:4] !== want.prob)
                    report_mismatch("probability", m_axis_tdata[20:4], want.prob);
                if (m_axis_tdata[24:21] !== want.best)
                    report_mismatch("best_class", m_axis_tdata[24:21], want.best);
                if (m_axis_tdata[41:25] !== want.conf)
                    report_mismatch("confidence", m_axis_tdata[41:25], want.conf);
                if (m_axis_tuser !== want.err)
                    report_mismatch("error", m_axis_tuser, want.err);
                if (m_axis_tlast !== want.last)
                    report_mismatch("final_result", m_axis_tlast, want.last);
            end
        end
        if (cycle_count > CYCLE_LIMIT) begin
            $display("softmax_argmax_decoder_top verification failed");
            $finish;
        end
    end

    // Extremes of the logit field, ties, flushing and the reset register value.
    task automatic test_directed_extremes();
        send_logit(16'h7FFF, 1'b0);
        send_logit(16'h8000, 1'b0);
        send_logit(16'h0000, 1'b0);
        send_logit(16'hFFFF, 1'b0);
        send_logit(16'h7FFF, 1'b0);   // tie with the first maximum
        send_logit(16'h0100, 1'b0);
        send_logit(16'hF4E9, 1'b0);   // exactly the flush limit below zero
        send_logit(16'h5555, 1'b0);
        send_logit(16'hAAAA, 1'b0);
        send_logit(16'h7F00, 1'b1);
        // All equal logits share the probability evenly.
        set_num_classes(5'd4);
        for (int k = 0; k < 4; k++) send_logit(16'h1234, k == 3);
    endtask

    // Count mismatch: too few, too many, one exact fit, and out-of-range register values.
    task automatic test_count_errors();
        set_num_classes(5'd3);
        send_vector(2, 300);
        send_vector(5, 300);
        send_vector(3, 300);
        set_num_classes(5'd0);
        send_vector(1, 100);
        set_num_classes(5'd31);
        send_vector(2, 100);
        for (int k = 0; k < 33; k++) send_logit(16'($urandom), k == 32);
        set_num_classes(5'd17);
        send_vector(3, 100);
    endtask

    task automatic test_size_extremes();
        set_num_classes(5'd1);
        send_vector(1, 32768);
        send_vector(1, 5);
        set_num_classes(5'd16);
        send_vector(16, 32768);
        send_vector(16, 1500);
    endtask

    // Mostly well-formed vectors at random sizes, with some broken lengths.
    task automatic test_random_vectors();
        int sent;
        int len;
        int n;
        sent = 0;
        idle_enable = 1'b1;
        while (sent < 130) begin
            if ($urandom_range(9) == 0) begin
                n = (($urandom_range(9) == 0) ? 16 : $urandom_range(1, 8));
                set_num_classes(5'(n));
            end
            n = num_classes_cfg;
            len = ($urandom_range(9) < 8) ? n : $urandom_range(1, 20);
            send_vector(len, ($urandom_range(1) != 0) ? 32768 : 1000);
            sent += len;
            if (sent > 40 && sent < 80) begin
                idle_enable = 1'b0;     // a stretch with no gaps at all
            end else begin
                idle_enable = 1'b1;
            end
        end
    endtask

    // The receiver stalls for a long time while the sender keeps offering.
    task automatic test_backpressure();
        set_num_classes(5'd8);
        hold_cycles = 3000;
        send_vector(8, 2000);
        send_vector(8, 2000);
        send_vector(8, 2000);
        drain_results();
    endtask

    initial begin
        error_count = 0;
        cycle_count = 0;
        idle_enable = 1'b0;
        sink_hold = 1'b0;
        hold_cycles = 0;
        num_classes_cfg = sad_pkg::NUM_CLASSES_RST;
        logit_count = '0;
        peak_logit = -16'sd32768;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_extremes();
        test_count_errors();
        test_size_extremes();
        test_backpressure();
        test_random_vectors();
        drain_results();

        if (error_count == 0) begin
            $display("softmax_argmax_decoder_top verification clean");
        end else begin
            $display("softmax_argmax_decoder_top verification failed");
        end
        $finish;
    end
endmodule
